>>> hdl/tbfe_pkg.sv
package tbfe_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int TAP_W     = 9;
    localparam int BAND_W    = 2;
    localparam int GAIN_W    = 4;
    localparam int NBANDS    = 3;
    localparam int FRAC_BITS = 15;
    localparam int CFG_IDX_W = 2;

    // item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // coefficient banks
    localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef coef_t [NBANDS-1:0]         coef_vec_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef gain_t [NBANDS-1:0]         gain_vec_t;

    // sequencer -> datapath controls
    typedef struct packed {
        logic clear;   // zero the accumulators
        logic issue;   // a tap read was issued this cycle
        logic live;    // issued tap holds a real sample (else reads as zero)
        logic scale;   // apply band gains to the finished sums
    } mac_ctrl_t;

endpackage

>>> hdl/tbfe_delay_ram.sv
module tbfe_delay_ram #(
    parameter int DEPTH  = 320,
    parameter int ADDR_W = 9
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  tbfe_pkg::sample_t     wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output tbfe_pkg::sample_t     rdata
);

    tbfe_pkg::sample_t mem [DEPTH];
    tbfe_pkg::sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/tbfe_coef_ram.sv
module tbfe_coef_ram #(
    parameter int DEPTH  = 320,
    parameter int ADDR_W = 9
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [tbfe_pkg::BAND_W-1:0]       wband,
    input  logic [ADDR_W-1:0]                 waddr,
    input  tbfe_pkg::coef_t                   wdata,
    input  logic [ADDR_W-1:0]                 raddr,
    output tbfe_pkg::coef_vec_t               rdata
);

    tbfe_pkg::coef_vec_t rdata_reg;

    // one bank per band, all read at the same tap
    for (genvar b = 0; b < tbfe_pkg::NBANDS; b++)
    begin : g_bank
        tbfe_pkg::coef_t mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (we && (wband == tbfe_pkg::BAND_W'(b)))
            begin
                mem[waddr] <= wdata;
            end
            rdata_reg[b] <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/tbfe_mac.sv
module tbfe_mac #(
    parameter int ACC_W = 41
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tbfe_pkg::mac_ctrl_t      ctrl,
    input  tbfe_pkg::sample_t        sample,
    input  tbfe_pkg::coef_vec_t      coefs,
    input  tbfe_pkg::gain_vec_t      gains,
    output logic                     busy,
    output tbfe_pkg::sample_t        result
);

    localparam int PROD_W   = tbfe_pkg::SAMPLE_W + tbfe_pkg::COEF_W;
    localparam int MUL_W    = ACC_W + tbfe_pkg::GAIN_W + 1;
    localparam int SCALED_W = ACC_W + tbfe_pkg::GAIN_W;
    localparam int TOTAL_W  = SCALED_W + 2;
    localparam int Q_W      = TOTAL_W - tbfe_pkg::FRAC_BITS;

    localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'((1 << (tbfe_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] SAT_MIN = -Q_W'(1 << (tbfe_pkg::SAMPLE_W - 1));
    localparam logic signed [TOTAL_W-1:0] ROUND_ADJ =
        TOTAL_W'((1 << tbfe_pkg::FRAC_BITS) - 1);

    // control pipe: d1 aligns with RAM read data, d2 with products
    logic d1_reg, d2_reg, live_d1_reg;

    logic signed [PROD_W-1:0]   prod_reg   [tbfe_pkg::NBANDS];
    logic signed [PROD_W-1:0]   prod_next  [tbfe_pkg::NBANDS];
    logic signed [ACC_W-1:0]    acc_reg    [tbfe_pkg::NBANDS];
    logic signed [ACC_W-1:0]    acc_next   [tbfe_pkg::NBANDS];
    logic signed [MUL_W-1:0]    mul        [tbfe_pkg::NBANDS];
    logic signed [SCALED_W-1:0] scaled_reg [tbfe_pkg::NBANDS];

    logic signed [TOTAL_W-1:0] total;
    logic signed [TOTAL_W-1:0] total_adj;
    logic signed [Q_W-1:0]     quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg      <= 1'b0;
            d2_reg      <= 1'b0;
            live_d1_reg <= 1'b0;
        end
        else
        begin
            d1_reg      <= ctrl.issue;
            live_d1_reg <= ctrl.live;
            d2_reg      <= d1_reg;
        end
    end

    always_comb
    begin
        for (int b = 0; b < tbfe_pkg::NBANDS; b++)
        begin
            prod_next[b] = live_d1_reg ? PROD_W'($signed(coefs[b]) * sample) : '0;
            if (ctrl.clear)
            begin
                acc_next[b] = '0;
            end
            else if (d2_reg)
            begin
                acc_next[b] = acc_reg[b] + ACC_W'(prod_reg[b]);
            end
            else
            begin
                acc_next[b] = acc_reg[b];
            end
            mul[b] = acc_reg[b] * $signed({1'b0, gains[b]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < tbfe_pkg::NBANDS; b++)
        begin
            if (d1_reg)
            begin
                prod_reg[b] <= prod_next[b];
            end
            acc_reg[b] <= acc_next[b];
            if (ctrl.scale)
            begin
                scaled_reg[b] <= mul[b][SCALED_W-1:0];
            end
        end
    end

    // band total, divide by 2^15 toward zero, saturate
    always_comb
    begin
        total = TOTAL_W'(scaled_reg[0]) + TOTAL_W'(scaled_reg[1]) + TOTAL_W'(scaled_reg[2]);
        total_adj = total[TOTAL_W-1] ? total + ROUND_ADJ : total;
        quot = Q_W'(total_adj >>> tbfe_pkg::FRAC_BITS);
        if (quot > SAT_MAX)
        begin
            result = SAT_MAX[tbfe_pkg::SAMPLE_W-1:0];
        end
        else if (quot < SAT_MIN)
        begin
            result = SAT_MIN[tbfe_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            result = quot[tbfe_pkg::SAMPLE_W-1:0];
        end
    end

    assign busy = d1_reg | d2_reg;

endmodule

>>> hdl/three_band_fir_equalizer.sv
// Flow: a sample transfer starts a pass that reads the delay line and coefficient RAMs one
// tap per cycle, scales the band sums by gain and loads the output register; no new item is
// taken until that pass ends (in_stall is high outside IDLE). A coefficient write completes while idle.
// Reset: rst_n is asynchronous, active low. Gains reset to 1. The delay line reads as
// zero through a fill count, so there is no clearing pass; coefficients are undefined.
module three_band_fir_equalizer #(
    parameter int TAPS = 320
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // input item channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic signed [tbfe_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [tbfe_pkg::BAND_W-1:0]          band_select,
    input  logic [tbfe_pkg::TAP_W-1:0]           tap_index,
    input  logic signed [tbfe_pkg::COEF_W-1:0]   coef_value,

    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [tbfe_pkg::SAMPLE_W-1:0] sample_out,

    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tbfe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tbfe_pkg::GAIN_W-1:0]          cfg_data
);

    localparam int PTR_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FILL_W    = $clog2(TAPS + 1);
    localparam int TAP_EXT_W = (PTR_W > tbfe_pkg::TAP_W) ? PTR_W : tbfe_pkg::TAP_W;
    // 2^30 worst product per tap, TAPS taps
    localparam int ACC_W     = 2 * tbfe_pkg::SAMPLE_W + $clog2(TAPS);

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(TAPS - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS);

    // Sequencer:
    //   IDLE  - takes items; coefficient writes finish here
    //   MAC   - one tap per cycle, newest sample first
    //   DRAIN - waits for the RAM/multiply pipe to empty, then scales by gain
    //   DONE  - loads the output register once it is free
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // circular delay line: wptr is the next head slot, rptr walks back in age
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [PTR_W-1:0]  k_reg, k_next;
    // samples held so far; older taps read as zero
    logic [FILL_W-1:0] fill_reg, fill_next;

    tbfe_pkg::gain_vec_t gain_reg;

    logic              out_valid_reg, out_valid_next;
    tbfe_pkg::sample_t out_data_reg;
    logic              out_load;

    logic in_xfer, sample_xfer, coef_xfer;
    logic [TAP_EXT_W-1:0] tap_ext;
    logic                 coef_we;

    tbfe_pkg::mac_ctrl_t  mac_ctrl;
    logic                 mac_busy;
    tbfe_pkg::sample_t    mac_result;
    tbfe_pkg::sample_t    dly_rdata;
    tbfe_pkg::coef_vec_t  coef_rdata;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign sample_xfer = in_xfer && (op == tbfe_pkg::OP_SAMPLE);
    assign coef_xfer   = in_xfer && (op == tbfe_pkg::OP_COEF);

    // out-of-range band or tap: write is dropped
    assign tap_ext = TAP_EXT_W'(tap_index);
    assign coef_we = coef_xfer
                  && (band_select < tbfe_pkg::BAND_W'(tbfe_pkg::NBANDS))
                  && (tap_ext < TAP_EXT_W'(TAPS));

    // user must change gains only while idle (not enforced); every config transfer is taken
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Storage
    // ---------------------------------------------------------------
    tbfe_delay_ram #(
        .DEPTH  (TAPS),
        .ADDR_W (PTR_W)
    ) u_delay_ram (
        .clk   (clk),
        .we    (sample_xfer),
        .waddr (wptr_reg),
        .wdata (sample_in),
        .raddr (rptr_reg),
        .rdata (dly_rdata)
    );

    tbfe_coef_ram #(
        .DEPTH  (TAPS),
        .ADDR_W (PTR_W)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .wband (band_select),
        .waddr (tap_ext[PTR_W-1:0]),
        .wdata (coef_value),
        .raddr (k_reg),
        .rdata (coef_rdata)
    );

    tbfe_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (dly_rdata),
        .coefs  (coef_rdata),
        .gains  (gain_reg),
        .busy   (mac_busy),
        .result (mac_result)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        k_next     = k_reg;
        fill_next  = fill_reg;
        mac_ctrl   = '0;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    // new sample lands at wptr this edge; the first read picks it up
                    mac_ctrl.clear = 1'b1;
                    rptr_next      = wptr_reg;
                    k_next         = '0;
                    wptr_next      = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
                    if (fill_reg != FILL_FULL)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    state_next = ST_MAC;
                end
            end

            ST_MAC:
            begin
                mac_ctrl.issue = 1'b1;
                mac_ctrl.live  = (FILL_W'(k_reg) < fill_reg);
                rptr_next      = (rptr_reg == '0) ? PTR_LAST : rptr_reg - PTR_W'(1);
                if (k_reg == PTR_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + PTR_W'(1);
                end
            end

            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    mac_ctrl.scale = 1'b1;
                    state_next     = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // hold the new result until the previous one is taken
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            k_reg         <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            gain_reg      <= {tbfe_pkg::NBANDS{tbfe_pkg::GAIN_RESET}};
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            k_reg         <= k_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tbfe_pkg::REG_LOW_GAIN:  gain_reg[tbfe_pkg::BAND_LOW]  <= cfg_data;
                    tbfe_pkg::REG_MID_GAIN:  gain_reg[tbfe_pkg::BAND_MID]  <= cfg_data;
                    tbfe_pkg::REG_HIGH_GAIN: gain_reg[tbfe_pkg::BAND_HIGH] <= cfg_data;
                    default:
                    begin
                        // unmapped index: ignored
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= mac_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond delay line depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (wptr_reg <= PTR_LAST) && (rptr_reg <= PTR_LAST))
        else $error("delay line pointer out of range");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mac_busy)
        else $error("MAC pipe busy while sequencer idle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_valid_reg && out_stall) |=> (state_reg == ST_DONE))
        else $error("result loaded over an untaken output");

endmodule
